/* rtl/lpd_pkg.sv */
// Shared constants and an encoding function for the LED pixel dimmer and SPI encoder.
package lpd_pkg;

    localparam int unsigned COLOUR_W      = 8;
    localparam int unsigned PIXEL_W       = 3 * COLOUR_W;
    localparam int unsigned LEVEL_W       = 5;
    localparam int unsigned SLOT_W        = 4;
    localparam int unsigned APB_ADDR_W    = 3;
    localparam int unsigned APB_DATA_W    = 32;

    localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 5'd16;
    localparam logic [SLOT_W-1:0]  LAST_SLOT    = 4'd11;
    localparam logic [3:0]         NIBBLE_ONE   = 4'hE;
    localparam logic [3:0]         NIBBLE_ZERO  = 4'h8;

    // Register select is bit 2 of the byte address.
    localparam logic REG_BRIGHTNESS = 1'b0;

    typedef struct packed {
        logic              busy;
        logic [SLOT_W-1:0] slot;
    } enc_status_t;

    function automatic logic [COLOUR_W-1:0] encode_pair(
        input logic [COLOUR_W-1:0] colour,
        input logic [1:0]          pair
    );
        logic [COLOUR_W-1:0] shifted;
        logic [3:0]          hi;
        logic [3:0]          lo;
        shifted = colour << {pair, 1'b0};
        hi      = shifted[7] ? NIBBLE_ONE : NIBBLE_ZERO;
        lo      = shifted[6] ? NIBBLE_ONE : NIBBLE_ZERO;
        return {hi, lo};
    endfunction

endpackage

/* rtl/lpd_dim.sv */
// Brightness scaling of one colour byte by shift-add approximations.
module lpd_dim (
    input  logic [lpd_pkg::LEVEL_W-1:0]  level,
    input  logic [lpd_pkg::COLOUR_W-1:0] colour_in,
    output logic [lpd_pkg::COLOUR_W-1:0] colour_out
);
    import lpd_pkg::*;

    logic [COLOUR_W-1:0] v1;
    logic [COLOUR_W-1:0] v2;
    logic [COLOUR_W-1:0] v3;
    logic [COLOUR_W-1:0] v4;

    assign v1 = colour_in >> 1;
    assign v2 = colour_in >> 2;
    assign v3 = colour_in >> 3;
    assign v4 = colour_in >> 4;

    always_comb begin
        case (level)
            5'd0:    colour_out = '0;
            5'd1:    colour_out = v4;
            5'd2:    colour_out = v3;
            5'd3:    colour_out = v3 + v4;
            5'd4:    colour_out = v2;
            5'd5:    colour_out = v2 + v4;
            5'd6:    colour_out = v2 + v3;
            5'd7:    colour_out = v1 - v4;
            5'd8:    colour_out = v1;
            5'd9:    colour_out = v1 + v4;
            5'd10:   colour_out = v1 + v3;
            5'd11:   colour_out = colour_in - v2 - v4;
            5'd12:   colour_out = colour_in - v2;
            5'd13:   colour_out = colour_in - v3 - v4;
            5'd14:   colour_out = colour_in - v3;
            5'd15:   colour_out = colour_in - v4;
            default: colour_out = colour_in;
        endcase
    end

endmodule

/* rtl/lpd_encoder.sv */
// Pixel serialiser: twelve SPI words per dimmed pixel into an output register.
module lpd_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load_valid,
    input  logic [lpd_pkg::PIXEL_W-1:0]   load_pixel,
    output logic                          load_ready,
    output lpd_pkg::enc_status_t          status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpd_pkg::COLOUR_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import lpd_pkg::*;

    logic [PIXEL_W-1:0]  word_reg,   word_next;
    logic                busy_reg,   busy_next;
    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic                tvalid_reg, tvalid_next;
    logic [COLOUR_W-1:0] tdata_reg,  tdata_next;
    logic                tlast_reg,  tlast_next;
    logic                advance;
    logic                at_last;
    logic [COLOUR_W-1:0] cur_colour;

    assign advance    = !tvalid_reg || m_tready;
    assign at_last    = (slot_reg == LAST_SLOT);
    assign load_ready = !busy_reg || (advance && at_last);

    always_comb begin
        case (slot_reg[3:2])
            2'd0:    cur_colour = word_reg[23:16];
            2'd1:    cur_colour = word_reg[15:8];
            2'd2:    cur_colour = word_reg[7:0];
            default: cur_colour = '0;
        endcase
    end

    always_comb begin
        word_next   = word_reg;
        busy_next   = busy_reg;
        slot_next   = slot_reg;
        tvalid_next = tvalid_reg;
        tdata_next  = tdata_reg;
        tlast_next  = tlast_reg;
        if (busy_reg && advance) begin
            tvalid_next = 1'b1;
            tdata_next  = encode_pair(cur_colour, slot_reg[1:0]);
            tlast_next  = at_last;
            busy_next   = !at_last;
            slot_next   = at_last ? '0 : slot_reg + 4'd1;
        end else if (advance) begin
            tvalid_next = 1'b0;
        end
        if (load_valid && load_ready) begin
            word_next = load_pixel;
            busy_next = 1'b1;
            slot_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            slot_reg   <= '0;
            tvalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            slot_reg   <= slot_next;
            tvalid_reg <= tvalid_next;
        end
        word_reg  <= word_next;
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
    end

    assign status.busy = busy_reg;
    assign status.slot = slot_reg;
    assign m_tvalid    = tvalid_reg;
    assign m_tdata     = tdata_reg;
    assign m_tlast     = tlast_reg;

endmodule

/* rtl/led_pixel_dim_and_spi_encode.sv */
// Top level: pixel dimmer and SPI bit encoder with APB brightness register.
//
// Slave stream: one pixel per word, three colour bytes in wire order.
// Master stream: twelve SPI words per pixel, each carrying two data bits
// coded as 1110 (one) or 1000 (zero), MSB first; tlast marks the twelfth.
// APB: brightness (0..16 sixteenths, above 16 passes through) at address 0.
// Dimming is applied as the pixel enters the input register.
// A pixel reaches the output via the input, word and output registers.
// Throughput: one SPI word per cycle while m_tready is high; the
// twelve-slot serialiser sets the pixel rate, and the next pixel waits in the
// input register so the stream runs without gaps.
// Reset: brightness returns to 16, both registers empty, no word pending.
// Stall: when m_tready is low the output word holds, the serialiser stops,
// and s_tready drops once the input register is also full.
module led_pixel_dim_and_spi_encode (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] color_first, [15:8] color_second, [23:16] color_third
    input  logic [lpd_pkg::PIXEL_W-1:0]      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] spi_byte
    output logic [lpd_pkg::COLOUR_W-1:0]     m_tdata,
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lpd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lpd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import lpd_pkg::*;

    logic [LEVEL_W-1:0]  bright_reg;
    logic [PIXEL_W-1:0]  pend_reg,       pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [PIXEL_W-1:0]  dimmed;
    logic                enc_ready;
    logic                enc_take;
    logic                s_accept;
    enc_status_t         enc_status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= BRIGHT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_BRIGHTNESS) begin
            bright_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_BRIGHTNESS) begin
            prdata = {{(APB_DATA_W-LEVEL_W){1'b0}}, bright_reg};
        end else begin
            prdata = '0;
        end
    end

    lpd_dim u_dim_first (
        .level      (bright_reg),
        .colour_in  (s_tdata[7:0]),
        .colour_out (dimmed[23:16])
    );

    lpd_dim u_dim_second (
        .level      (bright_reg),
        .colour_in  (s_tdata[15:8]),
        .colour_out (dimmed[15:8])
    );

    lpd_dim u_dim_third (
        .level      (bright_reg),
        .colour_in  (s_tdata[23:16]),
        .colour_out (dimmed[7:0])
    );

    assign enc_take = pend_valid_reg && enc_ready;
    assign s_tready = !pend_valid_reg || enc_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (enc_take) begin
            pend_valid_next = 1'b0;
        end
        if (s_accept) begin
            pend_next       = dimmed;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
        pend_reg <= pend_next;
    end

    lpd_encoder u_encoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (pend_valid_reg),
        .load_pixel (pend_reg),
        .load_ready (enc_ready),
        .status     (enc_status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        enc_status.slot <= LAST_SLOT)
        else $error("serialiser slot out of range");

    a_idle_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        !enc_status.busy |-> enc_status.slot == '0)
        else $error("idle serialiser with non-zero slot");

    a_pend_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> pend_valid_reg)
        else $error("accepted pixel not held");

    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg && !enc_ready |=> pend_valid_reg && $stable(pend_reg))
        else $error("pending pixel lost while serialiser busy");

    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        enc_status.busy && enc_status.slot == LAST_SLOT && (!m_tvalid || m_tready)
        |=> m_tvalid && m_tlast)
        else $error("twelfth word not flagged last");

endmodule
